[src/ansisgr_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ansisgr_pkg
// Shared types, character codes, SGR codes and helper functions for the
// ANSI SGR attribute parser.
// ----------------------------------------------------------------------------
package ansisgr_pkg;

    // Character codes
    localparam logic [7:0] C_NEWLINE   = 8'h0A;
    localparam logic [7:0] C_ESC       = 8'h1B;
    localparam logic [7:0] C_LBRACKET  = 8'h5B;
    localparam logic [7:0] C_SEMI      = 8'h3B;
    localparam logic [7:0] C_SGR_FINAL = 8'h6D;
    localparam logic [7:0] C_DIGIT_0   = 8'h30;
    localparam logic [7:0] C_DIGIT_9   = 8'h39;
    localparam logic [7:0] C_UPPER_A   = 8'h41;
    localparam logic [7:0] C_UPPER_Z   = 8'h5A;
    localparam logic [7:0] C_LOWER_A   = 8'h61;
    localparam logic [7:0] C_LOWER_Z   = 8'h7A;
    localparam logic [7:0] C_NONE      = 8'h00;

    // Attribute defaults and limits
    localparam logic [4:0] FG_DEFAULT = 5'd16;
    localparam logic [4:0] FG_WHITE   = 5'd7;
    localparam logic [4:0] FG_BRIGHT_BASE = 5'd8;
    localparam logic [3:0] BG_DEFAULT = 4'd8;
    localparam logic [9:0] PARAM_MAX  = 10'd999;

    // SGR codes
    localparam logic [9:0] SGR_RESET            = 10'd0;
    localparam logic [9:0] SGR_BOLD             = 10'd1;
    localparam logic [9:0] SGR_DIM              = 10'd2;
    localparam logic [9:0] SGR_UNDERLINE        = 10'd4;
    localparam logic [9:0] SGR_INVERSE          = 10'd7;
    localparam logic [9:0] SGR_NORMAL_INTENSITY = 10'd22;
    localparam logic [9:0] SGR_NO_UNDERLINE     = 10'd24;
    localparam logic [9:0] SGR_NO_INVERSE       = 10'd27;
    localparam logic [9:0] SGR_FG_FIRST         = 10'd30;
    localparam logic [9:0] SGR_FG_LAST          = 10'd37;
    localparam logic [9:0] SGR_BG_FIRST         = 10'd40;
    localparam logic [9:0] SGR_BG_LAST          = 10'd47;
    localparam logic [9:0] SGR_FG_BRIGHT_FIRST  = 10'd90;
    localparam logic [9:0] SGR_FG_BRIGHT_LAST   = 10'd96;
    localparam logic [9:0] SGR_FG_BRIGHT_WHITE  = 10'd97;

    // Flag bit positions
    localparam int FLAG_BOLD      = 0;
    localparam int FLAG_DIM       = 1;
    localparam int FLAG_UNDERLINE = 2;
    localparam int FLAG_INVERSE   = 3;

    // Result kinds
    localparam logic KIND_CHAR = 1'b0;
    localparam logic KIND_EOL  = 1'b1;

    // Result queue geometry (depth must be a power of two, at least 2)
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = QUEUE_AW + 1;

    typedef struct packed {
        logic [4:0] fg;
        logic [3:0] bg;
        logic [3:0] flags;
    } t_attr;

    localparam t_attr ATTR_DEFAULT = '{fg: FG_DEFAULT, bg: BG_DEFAULT, flags: 4'b0000};

    typedef struct packed {
        logic       kind;
        logic [7:0] char_out;
        t_attr      attr;
        logic       last;
    } t_result;

    // Up to two result words produced by one parsed byte
    typedef struct packed {
        logic [1:0] num;
        t_result    res0;
        t_result    res1;
    } t_push;

    function automatic t_result make_result(input logic kind, input logic [7:0] ch,
                                            input t_attr a);
        t_result r;
        r.kind     = kind;
        r.char_out = ch;
        r.attr     = a;
        r.last     = 1'b0;
        return r;
    endfunction

    // Apply one SGR code to an attribute set
    function automatic t_attr apply_code(input t_attr a, input logic [9:0] c);
        t_attr r;
        r = a;
        priority if (c == SGR_RESET) begin
            r = ATTR_DEFAULT;
        end else if (c == SGR_BOLD) begin
            r.flags[FLAG_BOLD] = 1'b1;
        end else if (c == SGR_DIM) begin
            r.flags[FLAG_DIM] = 1'b1;
        end else if (c == SGR_UNDERLINE) begin
            r.flags[FLAG_UNDERLINE] = 1'b1;
        end else if (c == SGR_INVERSE) begin
            r.flags[FLAG_INVERSE] = 1'b1;
        end else if (c == SGR_NORMAL_INTENSITY) begin
            r.flags[FLAG_BOLD] = 1'b0;
            r.flags[FLAG_DIM]  = 1'b0;
        end else if (c == SGR_NO_UNDERLINE) begin
            r.flags[FLAG_UNDERLINE] = 1'b0;
        end else if (c == SGR_NO_INVERSE) begin
            r.flags[FLAG_INVERSE] = 1'b0;
        end else if (c >= SGR_FG_FIRST && c <= SGR_FG_LAST) begin
            r.fg = 5'(c - SGR_FG_FIRST);
        end else if (c >= SGR_FG_BRIGHT_FIRST && c <= SGR_FG_BRIGHT_LAST) begin
            r.fg = 5'(c - SGR_FG_BRIGHT_FIRST) + FG_BRIGHT_BASE;
        end else if (c == SGR_FG_BRIGHT_WHITE) begin
            r.fg = FG_WHITE;
        end else if (c >= SGR_BG_FIRST && c <= SGR_BG_LAST) begin
            r.bg = 4'(c - SGR_BG_FIRST);
        end else begin
            r = a;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

[src/ansisgr_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ansisgr_if
// Valid/ready channels of the SGR parser: text bytes in, attributed
// characters and line ends out.
// ----------------------------------------------------------------------------
interface ansisgr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_in;

    modport source (output valid, output byte_in, input ready);
    modport sink   (input valid, input byte_in, output ready);
endinterface

interface ansisgr_out_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] char_out;
    logic [4:0] fg_color;
    logic [3:0] bg_color;
    logic       is_bold;
    logic       is_dim;
    logic       is_underline;
    logic       is_inverse;
    logic       last;

    modport source (output valid, output kind, output char_out, output fg_color,
                    output bg_color, output is_bold, output is_dim,
                    output is_underline, output is_inverse, output last,
                    input ready);
    modport sink   (input valid, input kind, input char_out, input fg_color,
                    input bg_color, input is_bold, input is_dim,
                    input is_underline, input is_inverse, input last,
                    output ready);
endinterface
`default_nettype wire

[src/ansi_sgr_attribute_parser.sv]
`default_nettype none
// Path: an accepted byte waits in the input register until the queue has room
//   for two words; its words then go into the 4-word queue that drives o_out.
// Throughput: one byte per cycle while the queue has room; words leave one per
//   cycle while o_out is ready; a lone ESC and a next byte not ESC give two words.
// Reset: synchronous, active low; attributes go to default, queue empties.
// ----------------------------------------------------------------------------
// ansi_sgr_attribute_parser
// Parses ANSI CSI/SGR escape sequences in a byte stream and emits each
// text byte with its current display attributes, and each line end.
// ----------------------------------------------------------------------------
module ansi_sgr_attribute_parser (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ansisgr_in_if.sink    i_in,
    ansisgr_out_if.source o_out
);
    import ansisgr_pkg::*;

    t_push w_push;
    logic  w_space_ok;

    ansisgr_parser u_parser (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .i_space_ok (w_space_ok),
        .o_push     (w_push)
    );

    ansisgr_out_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .o_space_ok (w_space_ok),
        .o_out      (o_out)
    );

    // Words are only written when the queue has room for both
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push.num != 2'd0) |-> w_space_ok)
        else $error("result written without queue space");

    // Single word carries the last marker
    a_last_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push.num == 2'd1) |-> w_push.res0.last)
        else $error("single word missing last");

    // Pair: only the second word is last, and the first is the passed ESC
    a_last_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push.num == 2'd2) |->
            (w_push.res1.last && !w_push.res0.last && w_push.res0.char_out == C_ESC))
        else $error("bad word pair");

    // A written line end is waiting in the queue on the next cycle
    a_eol_default: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push.num == 2'd1 && w_push.res0.kind == KIND_EOL) |=>
            (u_queue.r_count != '0))
        else $error("line end lost");

endmodule
`default_nettype wire

[src/ansisgr_parser.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ansisgr_parser
// Input byte register plus the escape/CSI state machine. One registered byte
// is parsed per cycle while the queue has room, into zero to two result words.
// ----------------------------------------------------------------------------
module ansisgr_parser (
    input  logic                i_clk,
    input  logic                i_rst_n,
    ansisgr_in_if.sink          i_in,
    input  logic                i_space_ok,
    output ansisgr_pkg::t_push  o_push
);
    import ansisgr_pkg::*;

    typedef enum logic [2:0] {
        PH_TEXT = 3'b001,
        PH_ESC  = 3'b010,
        PH_CSI  = 3'b100
    } t_phase;

    // Input stage
    logic       r_in_vld;
    logic [7:0] r_in_byte;

    // Parser state
    t_phase     r_phase,           n_phase;
    logic [9:0] r_param_value,     n_param_value;
    logic       r_param_has_digit, n_param_has_digit;
    logic       r_param_stopped,   n_param_stopped;
    logic       r_list_nonempty,   n_list_nonempty;
    t_attr      r_live,            n_live;
    t_attr      r_shadow,          n_shadow;

    logic       w_advance;
    logic       w_is_newline;
    logic       w_is_esc;
    logic       w_is_letter;
    logic       w_is_digit;
    logic [3:0] w_digit;
    logic [13:0] w_prod;
    t_result    w_text_res;

    // Byte leaves the input stage when the queue can take two words
    assign w_advance  = r_in_vld && i_space_ok;
    assign i_in.ready = !r_in_vld || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_in.ready) begin
            r_in_vld <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready) begin
            r_in_byte <= i_in.byte_in;
        end
    end

    // Byte classification
    assign w_is_newline = (r_in_byte == C_NEWLINE);
    assign w_is_esc     = (r_in_byte == C_ESC);
    assign w_is_letter  = (r_in_byte >= C_UPPER_A && r_in_byte <= C_UPPER_Z) ||
                          (r_in_byte >= C_LOWER_A && r_in_byte <= C_LOWER_Z);
    assign w_is_digit   = (r_in_byte >= C_DIGIT_0 && r_in_byte <= C_DIGIT_9);
    assign w_digit      = 4'(r_in_byte - C_DIGIT_0);

    // value * 10 + digit
    assign w_prod = {1'b0, r_param_value, 3'b000} + {3'b000, r_param_value, 1'b0} +
                    {10'd0, w_digit};

    // Result of a byte handled as plain text
    assign w_text_res = w_is_newline ? make_result(KIND_EOL, C_NONE, ATTR_DEFAULT)
                                     : make_result(KIND_CHAR, r_in_byte, r_live);

    // Next state and result words
    always_comb begin
        logic  v_text;
        logic  v_slot1;
        t_attr v_sh;

        v_text            = 1'b0;
        v_slot1           = 1'b0;
        v_sh              = r_shadow;
        n_phase           = r_phase;
        n_param_value     = r_param_value;
        n_param_has_digit = r_param_has_digit;
        n_param_stopped   = r_param_stopped;
        n_list_nonempty   = r_list_nonempty;
        n_live            = r_live;
        n_shadow          = r_shadow;
        o_push.num        = 2'd0;
        o_push.res0       = make_result(KIND_CHAR, C_ESC, r_live);
        o_push.res1       = w_text_res;

        if (w_advance) begin
            unique case (r_phase)
                PH_ESC: begin
                    if (r_in_byte == C_LBRACKET) begin
                        n_phase           = PH_CSI;
                        n_shadow          = r_live;
                        n_param_value     = '0;
                        n_param_has_digit = 1'b0;
                        n_param_stopped   = 1'b0;
                        n_list_nonempty   = 1'b0;
                    end else begin
                        // lone ESC goes out as text, then the byte is handled as text
                        v_text  = 1'b1;
                        v_slot1 = 1'b1;
                    end
                end
                PH_CSI: begin
                    if (w_is_newline) begin
                        v_text = 1'b1;
                    end else if (w_is_letter) begin
                        if (r_in_byte == C_SGR_FINAL) begin
                            if (!r_list_nonempty) begin
                                v_sh = apply_code(r_shadow, SGR_RESET);
                            end else if (r_param_has_digit) begin
                                v_sh = apply_code(r_shadow, r_param_value);
                            end
                            n_live   = v_sh;
                            n_shadow = v_sh;
                        end
                        n_param_value     = '0;
                        n_param_has_digit = 1'b0;
                        n_param_stopped   = 1'b0;
                        n_list_nonempty   = 1'b0;
                        n_phase           = PH_TEXT;
                    end else begin
                        n_list_nonempty = 1'b1;
                        if (r_in_byte == C_SEMI) begin
                            if (r_param_has_digit) begin
                                n_shadow = apply_code(r_shadow, r_param_value);
                            end
                            n_param_value     = '0;
                            n_param_has_digit = 1'b0;
                            n_param_stopped   = 1'b0;
                        end else if (w_is_digit) begin
                            if (!r_param_stopped) begin
                                n_param_value     = (w_prod > {4'd0, PARAM_MAX}) ?
                                                    PARAM_MAX : w_prod[9:0];
                                n_param_has_digit = 1'b1;
                            end
                        end else begin
                            n_param_stopped = 1'b1;
                        end
                    end
                end
                PH_TEXT: begin
                    v_text = 1'b1;
                end
                default: begin
                    v_text = 1'b1;
                end
            endcase

            // Plain-text handling, in slot 0 or after a passed-through ESC
            if (v_text) begin
                if (w_is_newline) begin
                    n_phase           = PH_TEXT;
                    n_param_value     = '0;
                    n_param_has_digit = 1'b0;
                    n_param_stopped   = 1'b0;
                    n_list_nonempty   = 1'b0;
                    n_live            = ATTR_DEFAULT;
                    n_shadow          = ATTR_DEFAULT;
                end else if (w_is_esc) begin
                    n_phase = PH_ESC;
                end else begin
                    n_phase = PH_TEXT;
                end

                if (w_is_esc) begin
                    o_push.num = v_slot1 ? 2'd1 : 2'd0;
                end else if (v_slot1) begin
                    o_push.res1 = w_text_res;
                    o_push.num  = 2'd2;
                end else begin
                    o_push.res0 = w_text_res;
                    o_push.num  = 2'd1;
                end
            end

            // Mark the final word of this byte
            if (o_push.num == 2'd1) begin
                o_push.res0.last = 1'b1;
            end
            if (o_push.num == 2'd2) begin
                o_push.res1.last = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase           <= PH_TEXT;
            r_param_value     <= '0;
            r_param_has_digit <= 1'b0;
            r_param_stopped   <= 1'b0;
            r_list_nonempty   <= 1'b0;
            r_live            <= ATTR_DEFAULT;
            r_shadow          <= ATTR_DEFAULT;
        end else if (w_advance) begin
            r_phase           <= n_phase;
            r_param_value     <= n_param_value;
            r_param_has_digit <= n_param_has_digit;
            r_param_stopped   <= n_param_stopped;
            r_list_nonempty   <= n_list_nonempty;
            r_live            <= n_live;
            r_shadow          <= n_shadow;
        end
    end

endmodule
`default_nettype wire

[src/ansisgr_out_queue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ansisgr_out_queue
// Small result queue: takes up to two words per cycle from the parser and
// hands out one word per cycle on the output channel while it is ready.
// ----------------------------------------------------------------------------
module ansisgr_out_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ansisgr_pkg::t_push i_push,
    output logic               o_space_ok,
    ansisgr_out_if.source      o_out
);
    import ansisgr_pkg::*;

    t_result               r_q [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   r_wr_ptr;
    logic [QUEUE_AW-1:0]   r_rd_ptr;
    logic [QUEUE_CW-1:0]   r_count;
    logic                  w_pop;
    t_result               w_head;

    assign w_pop      = o_out.valid && o_out.ready;
    // room for the worst case of two words
    assign o_space_ok = (r_count <= QUEUE_CW'(QUEUE_DEPTH - 2));

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push.num != 2'd0) begin
            r_q[r_wr_ptr] <= i_push.res0;
        end
        if (i_push.num == 2'd2) begin
            r_q[QUEUE_AW'(r_wr_ptr + 1'b1)] <= i_push.res1;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + QUEUE_AW'(i_push.num);
            r_rd_ptr <= r_rd_ptr + QUEUE_AW'(w_pop);
            r_count  <= r_count + QUEUE_CW'(i_push.num) - QUEUE_CW'(w_pop);
        end
    end

    // Head word onto the channel
    assign w_head             = r_q[r_rd_ptr];
    assign o_out.valid        = (r_count != '0);
    assign o_out.kind         = w_head.kind;
    assign o_out.char_out     = w_head.char_out;
    assign o_out.fg_color     = w_head.attr.fg;
    assign o_out.bg_color     = w_head.attr.bg;
    assign o_out.is_bold      = w_head.attr.flags[FLAG_BOLD];
    assign o_out.is_dim       = w_head.attr.flags[FLAG_DIM];
    assign o_out.is_underline = w_head.attr.flags[FLAG_UNDERLINE];
    assign o_out.is_inverse   = w_head.attr.flags[FLAG_INVERSE];
    assign o_out.last         = w_head.last;

endmodule
`default_nettype wire

[dv/ansi_sgr_attribute_parser_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ansi_sgr_attribute_parser_tb
// Feeds the SGR parser a byte stream in two parts. A short directed part
// comes first. A long random part follows, made mostly of well-formed escape
// sequences with random parameters and some broken ones, and mixed with
// text, newlines, lone ESCs and raw noise. A parser model in the scoreboard
// tracks the live and shadow attributes and predicts every output word. Each
// word is checked field by field, in order. Both handshakes stall at random.
// ----------------------------------------------------------------------------
module ansi_sgr_attribute_parser_tb;
    import ansisgr_pkg::*;

    // Parser model and expected-word store
    class sgr_scoreboard;
        typedef enum logic [1:0] {SCAN_TEXT, SCAN_ESC, SCAN_CSI} t_scan;

        t_scan       scan;
        logic [9:0]  num;
        bit          has_digit;
        bit          stopped;
        bit          nonempty;
        t_attr       live;
        t_attr       shadow;
        t_result     due_words[$];
        int unsigned errors;
        int unsigned words_checked;
        int unsigned line_ends;

        function new();
            clear_all();
        endfunction

        function void clear_num();
            num       = '0;
            has_digit = 1'b0;
            stopped   = 1'b0;
        endfunction

        function void clear_all();
            scan     = SCAN_TEXT;
            clear_num();
            nonempty = 1'b0;
            live     = '{fg: FG_DEFAULT, bg: BG_DEFAULT, flags: 4'b0000};
            shadow   = live;
        endfunction

        // One SGR code applied to the shadow attributes
        function void apply_sgr(logic [9:0] c);
            case (c)
                SGR_RESET:            shadow = '{fg: FG_DEFAULT, bg: BG_DEFAULT, flags: 4'b0000};
                SGR_BOLD:             shadow.flags[FLAG_BOLD] = 1'b1;
                SGR_DIM:              shadow.flags[FLAG_DIM] = 1'b1;
                SGR_UNDERLINE:        shadow.flags[FLAG_UNDERLINE] = 1'b1;
                SGR_INVERSE:          shadow.flags[FLAG_INVERSE] = 1'b1;
                SGR_NORMAL_INTENSITY: begin
                    shadow.flags[FLAG_BOLD] = 1'b0;
                    shadow.flags[FLAG_DIM]  = 1'b0;
                end
                SGR_NO_UNDERLINE:     shadow.flags[FLAG_UNDERLINE] = 1'b0;
                SGR_NO_INVERSE:       shadow.flags[FLAG_INVERSE] = 1'b0;
                SGR_FG_BRIGHT_WHITE:  shadow.fg = FG_WHITE;
                default: begin
                    if (c >= SGR_FG_FIRST && c <= SGR_FG_LAST)
                        shadow.fg = 5'(c - SGR_FG_FIRST);
                    else if (c >= SGR_FG_BRIGHT_FIRST && c <= SGR_FG_BRIGHT_LAST)
                        shadow.fg = 5'(c - SGR_FG_BRIGHT_FIRST) + FG_BRIGHT_BASE;
                    else if (c >= SGR_BG_FIRST && c <= SGR_BG_LAST)
                        shadow.bg = 4'(c - SGR_BG_FIRST);
                end
            endcase
        endfunction

        function void push_word(logic kind, logic [7:0] ch);
            t_result w;
            w.kind     = kind;
            w.char_out = ch;
            w.attr     = live;
            w.last     = 1'b0;
            due_words.insert(due_words.size(), w);
        endfunction

        // Byte seen in text state
        function void text_byte(logic [7:0] b);
            if (b == C_NEWLINE) begin
                clear_all();
                push_word(KIND_EOL, C_NONE);
            end else if (b == C_ESC) begin
                scan = SCAN_ESC;
            end else begin
                push_word(KIND_CHAR, b);
            end
        endfunction

        // Accepted input byte: advance the model, queue the words it causes
        function void parse_byte(logic [7:0] b);
            int  n0;
            bit  letter;
            logic [13:0] v;
            n0     = due_words.size();
            letter = (b >= C_UPPER_A && b <= C_UPPER_Z) || (b >= C_LOWER_A && b <= C_LOWER_Z);
            case (scan)
                SCAN_ESC: begin
                    if (b == C_LBRACKET) begin
                        scan     = SCAN_CSI;
                        shadow   = live;
                        clear_num();
                        nonempty = 1'b0;
                    end else begin
                        // lone ESC goes out as text, then the byte is handled normally
                        push_word(KIND_CHAR, C_ESC);
                        scan = SCAN_TEXT;
                        text_byte(b);
                    end
                end
                SCAN_CSI: begin
                    if (b == C_NEWLINE) begin
                        text_byte(b);
                    end else if (letter) begin
                        if (b == C_SGR_FINAL) begin
                            if (!nonempty)
                                apply_sgr(SGR_RESET);
                            else if (has_digit)
                                apply_sgr(num);
                            live = shadow;
                        end
                        clear_num();
                        nonempty = 1'b0;
                        scan     = SCAN_TEXT;
                    end else begin
                        nonempty = 1'b1;
                        if (b == C_SEMI) begin
                            if (has_digit)
                                apply_sgr(num);
                            clear_num();
                        end else if (b >= C_DIGIT_0 && b <= C_DIGIT_9) begin
                            if (!stopped) begin
                                v         = 14'(num) * 14'd10 + 14'(b - C_DIGIT_0);
                                num       = (v > 14'(PARAM_MAX)) ? PARAM_MAX : v[9:0];
                                has_digit = 1'b1;
                            end
                        end else begin
                            stopped = 1'b1;
                        end
                    end
                end
                default: text_byte(b);
            endcase
            if (due_words.size() > n0)
                due_words[due_words.size() - 1].last = 1'b1;
        endfunction

        task report(string what, int unsigned got, int unsigned want);
            if (errors < 50)
                $display("%0t: MISMATCH word %0d %s: got %0d, expected %0d",
                         $time, words_checked, what, got, want);
            errors++;
        endtask

        // Accepted output word against the oldest expectation
        task check_word(t_result got);
            t_result want;
            if (due_words.size() == 0) begin
                report("arrived with nothing expected, char", got.char_out, 0);
                return;
            end
            want = due_words.pop_front();
            if (got.kind !== want.kind)           report("kind", got.kind, want.kind);
            if (got.char_out !== want.char_out)   report("char_out", got.char_out, want.char_out);
            if (got.attr.fg !== want.attr.fg)     report("fg_color", got.attr.fg, want.attr.fg);
            if (got.attr.bg !== want.attr.bg)     report("bg_color", got.attr.bg, want.attr.bg);
            if (got.attr.flags[FLAG_BOLD] !== want.attr.flags[FLAG_BOLD])
                report("is_bold", got.attr.flags[FLAG_BOLD], want.attr.flags[FLAG_BOLD]);
            if (got.attr.flags[FLAG_DIM] !== want.attr.flags[FLAG_DIM])
                report("is_dim", got.attr.flags[FLAG_DIM], want.attr.flags[FLAG_DIM]);
            if (got.attr.flags[FLAG_UNDERLINE] !== want.attr.flags[FLAG_UNDERLINE])
                report("is_underline", got.attr.flags[FLAG_UNDERLINE],
                       want.attr.flags[FLAG_UNDERLINE]);
            if (got.attr.flags[FLAG_INVERSE] !== want.attr.flags[FLAG_INVERSE])
                report("is_inverse", got.attr.flags[FLAG_INVERSE],
                       want.attr.flags[FLAG_INVERSE]);
            if (got.last !== want.last)           report("last", got.last, want.last);
            words_checked++;
            if (want.kind == KIND_EOL)
                line_ends++;
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n;
    bit   steady = 1'b0;          // no stalls on either side while set
    int unsigned sent = 0;
    int unsigned sgr_count = 0;
    int unsigned code_list[$];

    sgr_scoreboard sb = new();

    ansisgr_in_if  in_ch();
    ansisgr_out_if out_ch();

    ansi_sgr_attribute_parser u_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always #5 clk = ~clk;

    // Input side: random gaps, then hold the byte until it is taken
    task automatic send_byte(logic [7:0] b);
        steady = (sent >= 400 && sent < 620);
        while (!steady && $urandom_range(99) < 34) begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.byte_in <= b;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        sb.parse_byte(b);
        sent++;
    endtask

    // Decimal parameter text
    task automatic send_code(int unsigned v);
        string s;
        s = $sformatf("%0d", v);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    // Any byte that is no digit and neither ends a parameter nor the sequence nor the line
    function automatic logic [7:0] pick_junk();
        logic [7:0] b;
        do
            b = 8'($urandom_range(255));
        while ((b >= C_UPPER_A && b <= C_UPPER_Z) || (b >= C_LOWER_A && b <= C_LOWER_Z) ||
               (b >= C_DIGIT_0 && b <= C_DIGIT_9) || b == C_NEWLINE || b == C_SEMI);
        return b;
    endfunction

    function automatic int unsigned pick_code();
        return code_list[$urandom_range(code_list.size() - 1)];
    endfunction

    // Escape sequence with random parameters, mostly ending in 'm'
    task automatic send_sgr();
        int np;
        int sel;
        logic [7:0] fin;
        sgr_count++;
        send_byte(C_ESC);
        send_byte(C_LBRACKET);
        np = $urandom_range(0, 4);
        for (int k = 0; k < np; k++) begin
            sel = $urandom_range(99);
            if (sel < 55) begin
                send_code(pick_code());
            end else if (sel < 68) begin
                send_code($urandom_range(0, 99));
            end else if (sel < 76) begin
                send_code($urandom_range(100, 99999));   // 100 and up matches no code; above 999 it saturates
            end else if (sel < 82) begin
                send_byte(C_DIGIT_0);
                send_code(pick_code());
            end else if (sel < 90) begin
                send_code(pick_code());
                send_byte(pick_junk());
                send_code($urandom_range(0, 99));
            end else if (sel < 95) begin
                send_byte(pick_junk());
                send_code(pick_code());
            end
            if (k < np - 1 || $urandom_range(7) == 0)
                send_byte(C_SEMI);
        end
        sel = $urandom_range(99);
        if (sel < 85) begin
            send_byte(C_SGR_FINAL);
        end else if (sel < 93) begin
            do
                fin = $urandom_range(1) ? 8'($urandom_range(C_UPPER_A, C_UPPER_Z))
                                        : 8'($urandom_range(C_LOWER_A, C_LOWER_Z));
            while (fin == C_SGR_FINAL);
            send_byte(fin);
        end else if (sel < 97) begin
            send_byte(C_NEWLINE);
        end
        // otherwise the sequence stays open into whatever follows
    endtask

    // Output side: check accepted words, stall at random
    always @(posedge clk) begin : out_mon
        t_result got;
        if (rst_n && out_ch.valid && out_ch.ready) begin
            got.kind                   = out_ch.kind;
            got.char_out               = out_ch.char_out;
            got.attr.fg                = out_ch.fg_color;
            got.attr.bg                = out_ch.bg_color;
            got.attr.flags[FLAG_BOLD]      = out_ch.is_bold;
            got.attr.flags[FLAG_DIM]       = out_ch.is_dim;
            got.attr.flags[FLAG_UNDERLINE] = out_ch.is_underline;
            got.attr.flags[FLAG_INVERSE]   = out_ch.is_inverse;
            got.last                   = out_ch.last;
            sb.check_word(got);
        end
        out_ch.ready <= steady || ($urandom_range(99) >= 34);
    end

    // Stimulus
    initial begin
        int unsigned target;
        int sel;
        int n;
        logic [7:0] b;

        rst_n         <= 1'b0;
        in_ch.valid   <= 1'b0;
        in_ch.byte_in <= '0;

        code_list = '{SGR_RESET, SGR_BOLD, SGR_DIM, SGR_UNDERLINE, SGR_INVERSE,
                      SGR_NORMAL_INTENSITY, SGR_NO_UNDERLINE, SGR_NO_INVERSE,
                      SGR_FG_BRIGHT_WHITE};
        for (int c = SGR_FG_FIRST; c <= SGR_FG_LAST; c++)
            code_list.insert(code_list.size(), c);
        for (int c = SGR_BG_FIRST; c <= SGR_BG_LAST; c++)
            code_list.insert(code_list.size(), c);
        for (int c = SGR_FG_BRIGHT_FIRST; c <= SGR_FG_BRIGHT_LAST; c++)
            code_list.insert(code_list.size(), c);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: byte extremes
        send_byte(8'h00);
        send_byte(8'hFF);
        // bold; underline with junk and a stray digit; param with no digits; fg 1
        send_byte(C_ESC);
        send_byte(C_LBRACKET);
        send_code(SGR_BOLD);
        send_byte(C_SEMI);
        send_code(SGR_UNDERLINE);
        send_byte(":");
        send_byte("9");
        send_byte(C_SEMI);
        send_byte(":");
        send_byte(C_SEMI);
        send_code(SGR_FG_FIRST + 1);
        send_byte(C_SGR_FINAL);
        send_byte("A");
        // non-SGR final letter: no effect
        send_byte(C_ESC);
        send_byte(C_LBRACKET);
        send_byte("H");
        // ESC without '[' comes out as text
        send_byte(C_ESC);
        send_byte("x");
        // empty list resets
        send_byte(C_ESC);
        send_byte(C_LBRACKET);
        send_byte(C_SGR_FINAL);
        // newline inside an open sequence
        send_byte(C_ESC);
        send_byte(C_LBRACKET);
        send_byte(C_NEWLINE);

        // Random part
        target = sent + 1050;
        while (sent < target) begin
            sel = $urandom_range(99);
            if (sel < 40) begin
                send_sgr();
            end else if (sel < 78) begin
                n = $urandom_range(1, 6);
                repeat (n) begin
                    do
                        b = 8'($urandom_range(255));
                    while (b == C_NEWLINE || b == C_ESC);
                    send_byte(b);
                end
            end else if (sel < 86) begin
                send_byte(C_NEWLINE);
            end else if (sel < 93) begin
                send_byte(C_ESC);
                send_byte(8'($urandom_range(255)));
            end else begin
                send_byte(8'($urandom_range(255)));
            end
        end
        in_ch.valid <= 1'b0;

        // Drain, then give trailing words a chance to show up
        while (sb.due_words.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);

        $display("Sent %0d bytes with %0d random escape sequences", sent, sgr_count);
        $display("Checked %0d output words, %0d of them line ends",
                 sb.words_checked, sb.line_ends);
        if (sb.errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #(2_000_000);
        $display("Timeout with %0d words still expected", sb.due_words.size());
        $display("Test completed with failures");
        $finish;
    end

endmodule

[filelist.f]
src/ansisgr_pkg.sv
src/ansisgr_if.sv
src/ansisgr_parser.sv
src/ansisgr_out_queue.sv
src/ansi_sgr_attribute_parser.sv
dv/ansi_sgr_attribute_parser_tb.sv
